// ===== hw/rtl/order_statistic_set_core_macros.svh =====
// Assertion macros for the order statistic set RTL; only oss_ctrl uses them.
// Each use expects signals named clk and rst in the enclosing module.
`ifndef ORDER_STATISTIC_SET_CORE_MACROS_SVH
`define ORDER_STATISTIC_SET_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OSS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define OSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OSS_ASSERT_ALWAYS(label, expr, msg)
`define OSS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/oss_pkg.sv =====
`default_nettype none
package oss_pkg;

  localparam int KEY_W     = 12;
  localparam int KEY_SPACE = 1 << KEY_W;
  localparam int CNT_W     = KEY_W + 1;
  localparam int LVL_W     = $clog2(KEY_W);

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [1:0]       op_t;

  localparam lvl_t LAST_LVL = lvl_t'(KEY_W - 1);

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_ERASE  = 2'd1;
  localparam op_t OP_SELECT = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P_RD,
    ST_P_CHK,
    ST_U_RD,
    ST_U_WR,
    ST_S_CHK,
    ST_S_RD,
    ST_S_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic cnt_re;
    key_t cnt_raddr;
    logic cnt_we;
    key_t cnt_waddr;
    cnt_t cnt_wdata;
    logic pres_re;
    key_t pres_raddr;
    logic pres_we;
    key_t pres_waddr;
    logic pres_wdata;
  } mem_req_t;

  typedef struct packed {
    logic ok;
    key_t found_key;
    cnt_t set_size;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/oss_alu.sv =====
`default_nettype none
module oss_alu (
  input  oss_pkg::cnt_t a,
  input  oss_pkg::cnt_t b,
  input  logic          sub,
  output oss_pkg::cnt_t sum,
  output logic          borrow
);

  logic [oss_pkg::CNT_W:0] wide;

  assign wide   = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
  assign sum    = wide[oss_pkg::CNT_W-1:0];
  assign borrow = wide[oss_pkg::CNT_W];

endmodule
`default_nettype wire

// ===== hw/rtl/oss_store.sv =====
`default_nettype none
module oss_store (
  input  logic              clk,
  input  oss_pkg::mem_req_t req,
  output oss_pkg::cnt_t     cnt_rdata,
  output logic              pres_rdata
);

  // Node counts of the count tree, indexed in heap order; entries 0 and 1 are unused.
  oss_pkg::cnt_t cnt_mem [oss_pkg::KEY_SPACE];
  logic          pres_mem [oss_pkg::KEY_SPACE];

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[req.cnt_waddr] <= req.cnt_wdata;
    end
    if (req.cnt_re) begin
      cnt_rdata <= cnt_mem[req.cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.pres_we) begin
      pres_mem[req.pres_waddr] <= req.pres_wdata;
    end
    if (req.pres_re) begin
      pres_rdata <= pres_mem[req.pres_raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/oss_ctrl.sv =====
`default_nettype none
`include "order_statistic_set_core_macros.svh"
module oss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  oss_pkg::op_t      op,
  input  oss_pkg::key_t     key,
  input  oss_pkg::key_t     rank,
  input  logic              out_free,
  output logic              res_valid,
  output oss_pkg::res_t     res,
  output oss_pkg::mem_req_t mem_req,
  input  oss_pkg::cnt_t     cnt_rdata,
  input  logic              pres_rdata
);

  oss_pkg::state_t state, state_next;
  oss_pkg::op_t    op_q, op_q_next;
  oss_pkg::key_t   key_sh, key_sh_next;
  oss_pkg::cnt_t   rem, rem_next;
  oss_pkg::key_t   node, node_next;
  oss_pkg::lvl_t   depth, depth_next;
  oss_pkg::cnt_t   size, size_next;
  oss_pkg::key_t   clr, clr_next;
  logic            res_ok, res_ok_next;
  oss_pkg::key_t   res_key, res_key_next;

  oss_pkg::cnt_t alu_a, alu_b, alu_sum, left_cnt;
  oss_pkg::key_t child;
  logic          alu_sub, alu_borrow, upd_go, last_lvl, accept;

  oss_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  assign accept   = in_valid && in_ready;
  assign last_lvl = (depth == oss_pkg::LAST_LVL);
  assign child    = {node[oss_pkg::KEY_W-2:0], 1'b0};
  assign left_cnt = last_lvl ? oss_pkg::cnt_t'(pres_rdata) : cnt_rdata;
  assign upd_go   = ((op_q == oss_pkg::OP_INSERT) && !pres_rdata) ||
                    ((op_q == oss_pkg::OP_ERASE) && pres_rdata);
  assign res      = '{ok: res_ok, found_key: res_key, set_size: size};

  always_comb begin
    state_next = state;
    case (state)
      oss_pkg::ST_CLEAR: begin
        if (&clr) state_next = oss_pkg::ST_IDLE;
      end
      oss_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == oss_pkg::OP_INSERT || op == oss_pkg::OP_ERASE) begin
            state_next = oss_pkg::ST_P_RD;
          end else if (op == oss_pkg::OP_SELECT) begin
            state_next = oss_pkg::ST_S_CHK;
          end else begin
            state_next = oss_pkg::ST_DONE;
          end
        end
      end
      oss_pkg::ST_P_RD:  state_next = oss_pkg::ST_P_CHK;
      oss_pkg::ST_P_CHK: state_next = upd_go ? oss_pkg::ST_U_RD : oss_pkg::ST_DONE;
      oss_pkg::ST_U_RD:  state_next = oss_pkg::ST_U_WR;
      oss_pkg::ST_U_WR:  state_next = last_lvl ? oss_pkg::ST_DONE : oss_pkg::ST_U_RD;
      oss_pkg::ST_S_CHK: state_next = alu_borrow ? oss_pkg::ST_S_RD : oss_pkg::ST_DONE;
      oss_pkg::ST_S_RD:  state_next = oss_pkg::ST_S_CMP;
      oss_pkg::ST_S_CMP: state_next = last_lvl ? oss_pkg::ST_DONE : oss_pkg::ST_S_RD;
      oss_pkg::ST_DONE: begin
        if (out_free) state_next = oss_pkg::ST_IDLE;
      end
      default: state_next = oss_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_req   = '0;
    alu_a     = size;
    alu_b     = oss_pkg::cnt_t'(1);
    alu_sub   = (op_q == oss_pkg::OP_ERASE);
    case (state)
      oss_pkg::ST_CLEAR: begin
        mem_req.cnt_we     = 1'b1;
        mem_req.cnt_waddr  = clr;
        mem_req.pres_we    = 1'b1;
        mem_req.pres_waddr = clr;
      end
      oss_pkg::ST_IDLE: in_ready = 1'b1;
      oss_pkg::ST_P_RD: begin
        mem_req.pres_re    = 1'b1;
        mem_req.pres_raddr = key_sh;
      end
      oss_pkg::ST_P_CHK: begin
        mem_req.pres_we    = upd_go;
        mem_req.pres_waddr = key_sh;
        mem_req.pres_wdata = (op_q == oss_pkg::OP_INSERT);
      end
      oss_pkg::ST_U_RD: begin
        mem_req.cnt_re    = 1'b1;
        mem_req.cnt_raddr = node;
      end
      oss_pkg::ST_U_WR: begin
        alu_a             = cnt_rdata;
        mem_req.cnt_we    = 1'b1;
        mem_req.cnt_waddr = node;
        mem_req.cnt_wdata = alu_sum;
      end
      oss_pkg::ST_S_CHK: begin
        alu_a   = rem;
        alu_b   = size;
        alu_sub = 1'b1;
      end
      oss_pkg::ST_S_RD: begin
        mem_req.cnt_re     = !last_lvl;
        mem_req.cnt_raddr  = child;
        mem_req.pres_re    = last_lvl;
        mem_req.pres_raddr = child;
      end
      oss_pkg::ST_S_CMP: begin
        alu_a   = rem;
        alu_b   = left_cnt;
        alu_sub = 1'b1;
      end
      oss_pkg::ST_DONE: res_valid = out_free;
      default: ;
    endcase
  end

  always_comb begin
    op_q_next    = op_q;
    key_sh_next  = key_sh;
    rem_next     = rem;
    node_next    = node;
    depth_next   = depth;
    size_next    = size;
    clr_next     = clr;
    res_ok_next  = res_ok;
    res_key_next = res_key;
    case (state)
      oss_pkg::ST_CLEAR: clr_next = clr + oss_pkg::key_t'(1);
      oss_pkg::ST_IDLE: begin
        if (accept) begin
          op_q_next    = op;
          key_sh_next  = key;
          rem_next     = oss_pkg::cnt_t'(rank);
          node_next    = oss_pkg::key_t'(1);
          depth_next   = '0;
          res_ok_next  = 1'b0;
          res_key_next = '0;
        end
      end
      oss_pkg::ST_P_CHK: begin
        if (upd_go) begin
          size_next   = alu_sum;
          res_ok_next = 1'b1;
          node_next   = {node[oss_pkg::KEY_W-2:0], key_sh[oss_pkg::KEY_W-1]};
          key_sh_next = key_sh << 1;
          depth_next  = depth + oss_pkg::lvl_t'(1);
        end
      end
      oss_pkg::ST_U_WR: begin
        node_next   = {node[oss_pkg::KEY_W-2:0], key_sh[oss_pkg::KEY_W-1]};
        key_sh_next = key_sh << 1;
        depth_next  = depth + oss_pkg::lvl_t'(1);
      end
      oss_pkg::ST_S_CHK: res_ok_next = alu_borrow;
      oss_pkg::ST_S_CMP: begin
        if (alu_borrow) begin
          node_next = child;
        end else begin
          node_next = {node[oss_pkg::KEY_W-2:0], 1'b1};
          rem_next  = alu_sum;
        end
        depth_next = depth + oss_pkg::lvl_t'(1);
        if (last_lvl) res_key_next = node_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oss_pkg::ST_CLEAR;
      clr   <= '0;
      size  <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      size  <= size_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q    <= op_q_next;
    key_sh  <= key_sh_next;
    rem     <= rem_next;
    node    <= node_next;
    depth   <= depth_next;
    res_ok  <= res_ok_next;
    res_key <= res_key_next;
  end

  `OSS_ASSERT_ALWAYS(a_size_range, size <= oss_pkg::cnt_t'(oss_pkg::KEY_SPACE), "set size out of range")
  `OSS_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "accepted a second transaction while busy")
  `OSS_ASSERT_NEXT(a_insert_grows, state == oss_pkg::ST_P_CHK && upd_go && op_q == oss_pkg::OP_INSERT, size == $past(size) + oss_pkg::cnt_t'(1), "insert did not grow the set")
  `OSS_ASSERT_NEXT(a_erase_shrinks, state == oss_pkg::ST_P_CHK && upd_go && op_q == oss_pkg::OP_ERASE, size == $past(size) - oss_pkg::cnt_t'(1), "erase did not shrink the set")

endmodule
`default_nettype wire

// ===== hw/rtl/order_statistic_set_core.sv =====
// Order statistic set: holds a set of 12-bit keys and serves insert, erase and
// select-by-rank, each as one transaction on the input channel (op, key, rank)
// answered by exactly one transaction on the output channel (ok, found_key,
// set_size). Op 0 inserts key, op 1 erases key, op 2 selects the key of the
// given zero-based ascending rank; op 3 changes nothing.
// After reset the block clears its count tree and presence memories, one entry
// per cycle; in_ready stays low during that pass.
// One transaction is worked on at a time. A count tree in heap order is walked
// from the root a level at a time; each level needs a memory read whose
// registered data feeds the shared adder before the next step.
// A successful insert or erase and a select that finds its rank walk every
// level before the result goes to the output register; a rejected insert or
// erase, a rank beyond the set size and op 3 skip the walk.
// The next transaction is taken the cycle after the result is registered.
// While the receiver stalls, the result waits in the output register and the
// block holds its finished transaction without accepting a new one.
`default_nettype none
module order_statistic_set_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  oss_pkg::op_t  op,
  input  oss_pkg::key_t key,
  input  oss_pkg::key_t rank,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          ok,
  output oss_pkg::key_t found_key,
  output oss_pkg::cnt_t set_size
);

  oss_pkg::mem_req_t mem_req;
  oss_pkg::res_t     res;
  oss_pkg::cnt_t     cnt_rdata;
  logic              pres_rdata;
  logic              res_valid;
  logic              out_free;

  assign out_free = !out_valid || out_ready;

  oss_store u_store (
    .clk        (clk),
    .req        (mem_req),
    .cnt_rdata  (cnt_rdata),
    .pres_rdata (pres_rdata)
  );

  oss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .key        (key),
    .rank       (rank),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .mem_req    (mem_req),
    .cnt_rdata  (cnt_rdata),
    .pres_rdata (pres_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      ok        <= res.ok;
      found_key <= res.found_key;
      set_size  <= res.set_size;
    end
  end

endmodule
`default_nettype wire
